@@ rtl/ecv_pkg.sv @@
package ecv_pkg;

    localparam int unsigned WidthW   = 16;
    localparam int unsigned CountW   = 8;
    localparam int unsigned SilenceW = 16;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;

    localparam logic [CountW-1:0]   ErrThrReset  = 8'd10;
    localparam logic [SilenceW-1:0] SilThrReset  = 16'd1000;
    localparam logic [CountW-1:0]   CountMax     = 8'd255;
    localparam logic [SilenceW-1:0] SilenceMax   = 16'd65535;

    localparam logic [CfgIdxW-1:0] RegErrThr = 2'd0;
    localparam logic [CfgIdxW-1:0] RegSilThr = 2'd1;

    localparam logic [1:0] FuncTick    = 2'd0;
    localparam logic [1:0] FuncCapture = 2'd1;
    localparam logic [1:0] FuncAck     = 2'd2;

    localparam logic [2:0] StNone     = 3'd0;
    localparam logic [2:0] StOverflow = 3'd1;
    localparam logic [2:0] StNoTrig   = 3'd2;
    localparam logic [2:0] StStored   = 3'd3;
    localparam logic [2:0] StDropped  = 3'd4;
    localparam logic [2:0] StNoCc3    = 3'd5;

    typedef struct packed {
        logic [1:0]        func;
        logic              cc3_flag;
        logic              trigger_seen;
        logic              overflow_seen;
        logic [WidthW-1:0] capture_value;
    } ecv_in_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [WidthW-1:0] pulse_width;
        logic              measurement_ready;
        logic              overflow_error;
        logic              no_trigger_error;
        logic              sensor_silent;
    } ecv_out_t;

    typedef enum logic [1:0] {
        OP_NOP     = 2'd0,
        OP_TICK    = 2'd1,
        OP_CAPTURE = 2'd2,
        OP_ACK     = 2'd3
    } ecv_op_t;

    typedef enum logic [1:0] {
        CLS_NOCC3  = 2'd0,
        CLS_NOTRIG = 2'd1,
        CLS_OVF    = 2'd2,
        CLS_GOOD   = 2'd3
    } ecv_cls_t;

    typedef struct packed {
        ecv_op_t           op;
        ecv_cls_t          cls;
        logic [WidthW-1:0] width;
    } ecv_cmd_t;

endpackage

@@ rtl/ecv_front.sv @@
module ecv_front (
    input  logic             in_valid,
    output logic             in_ready,
    input  ecv_pkg::ecv_in_t in_data,
    output logic             push,
    output ecv_pkg::ecv_cmd_t cmd,
    input  logic             q_full
);
    import ecv_pkg::*;

    assign in_ready = !q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cmd.width = in_data.capture_value;
        cmd.op    = OP_NOP;
        unique case (in_data.func)
            FuncTick:    cmd.op = OP_TICK;
            FuncCapture: cmd.op = OP_CAPTURE;
            FuncAck:     cmd.op = OP_ACK;
            default:     cmd.op = OP_NOP;
        endcase
        if (!in_data.cc3_flag)
            cmd.cls = CLS_NOCC3;
        else if (!in_data.trigger_seen)
            cmd.cls = CLS_NOTRIG;
        else if (in_data.overflow_seen)
            cmd.cls = CLS_OVF;
        else
            cmd.cls = CLS_GOOD;
    end

endmodule

@@ rtl/ecv_queue.sv @@
module ecv_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ecv_pkg::ecv_cmd_t push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              q_valid,
    output ecv_pkg::ecv_cmd_t head
);
    import ecv_pkg::*;

    localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    ecv_cmd_t        mem_reg [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;

    assign full    = (count_reg == FullCnt);
    assign q_valid = (count_reg != '0);
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

@@ rtl/ecv_back.sv @@
module ecv_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [ecv_pkg::CfgIdxW-1:0]     cfg_index,
    input  logic [ecv_pkg::CfgDataW-1:0]    cfg_data,
    input  logic                            q_valid,
    input  ecv_pkg::ecv_cmd_t               head,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output ecv_pkg::ecv_out_t               out_data
);
    import ecv_pkg::*;

    logic [CountW-1:0]   err_thr_reg;
    logic [SilenceW-1:0] sil_thr_reg;

    logic [WidthW-1:0]   width_reg, width_next;
    logic                rdy_reg, rdy_next;
    logic [2:0]          status_reg, status_next;
    logic [CountW-1:0]   ovf_cnt_reg, ovf_cnt_next;
    logic [CountW-1:0]   nt_cnt_reg, nt_cnt_next;
    logic [CountW-1:0]   good_cnt_reg, good_cnt_next;
    logic [SilenceW-1:0] sil_cnt_reg, sil_cnt_next;
    logic                ovf_err_reg, ovf_err_next;
    logic                nt_err_reg, nt_err_next;
    logic                silent_reg, silent_next;

    logic                out_valid_reg;
    ecv_out_t            out_data_reg;

    assign pop       = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        width_next    = width_reg;
        rdy_next      = rdy_reg;
        status_next   = status_reg;
        ovf_cnt_next  = ovf_cnt_reg;
        nt_cnt_next   = nt_cnt_reg;
        good_cnt_next = good_cnt_reg;
        sil_cnt_next  = sil_cnt_reg;
        ovf_err_next  = ovf_err_reg;
        nt_err_next   = nt_err_reg;
        silent_next   = silent_reg;
        unique case (head.op)
            OP_TICK:
            begin
                if (sil_cnt_reg != SilenceMax)
                    sil_cnt_next = sil_cnt_reg + 1'b1;
                if (sil_cnt_next >= sil_thr_reg)
                    silent_next = 1'b1;
            end
            OP_ACK:
                rdy_next = 1'b0;
            OP_CAPTURE:
            begin
                if (head.cls == CLS_NOCC3)
                    status_next = StNoCc3;
                else
                begin
                    sil_cnt_next = '0;
                    silent_next  = 1'b0;
                    unique case (head.cls)
                        CLS_NOTRIG:
                        begin
                            status_next = StNoTrig;
                            if (nt_cnt_reg != CountMax)
                                nt_cnt_next = nt_cnt_reg + 1'b1;
                            if (nt_cnt_next >= err_thr_reg)
                            begin
                                good_cnt_next = '0;
                                nt_err_next   = 1'b1;
                            end
                        end
                        CLS_OVF:
                        begin
                            status_next = StOverflow;
                            if (ovf_cnt_reg != CountMax)
                                ovf_cnt_next = ovf_cnt_reg + 1'b1;
                            if (ovf_cnt_next >= err_thr_reg)
                            begin
                                good_cnt_next = '0;
                                ovf_err_next  = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!rdy_reg)
                            begin
                                width_next  = head.width;
                                rdy_next    = 1'b1;
                                status_next = StStored;
                            end
                            else
                                status_next = StDropped;
                        end
                    endcase
                    if (good_cnt_next != CountMax)
                        good_cnt_next = good_cnt_next + 1'b1;
                    if (good_cnt_next >= err_thr_reg)
                    begin
                        ovf_cnt_next = '0;
                        nt_cnt_next  = '0;
                        ovf_err_next = 1'b0;
                        nt_err_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_thr_reg  <= ErrThrReset;
            sil_thr_reg  <= SilThrReset;
            width_reg    <= '0;
            rdy_reg      <= 1'b0;
            status_reg   <= StNone;
            ovf_cnt_reg  <= '0;
            nt_cnt_reg   <= '0;
            good_cnt_reg <= '0;
            sil_cnt_reg  <= '0;
            ovf_err_reg  <= 1'b0;
            nt_err_reg   <= 1'b0;
            silent_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                if (cfg_index == RegErrThr)
                    err_thr_reg <= cfg_data[CountW-1:0];
                else if (cfg_index == RegSilThr)
                    sil_thr_reg <= cfg_data[SilenceW-1:0];
            end
            if (pop)
            begin
                width_reg    <= width_next;
                rdy_reg      <= rdy_next;
                status_reg   <= status_next;
                ovf_cnt_reg  <= ovf_cnt_next;
                nt_cnt_reg   <= nt_cnt_next;
                good_cnt_reg <= good_cnt_next;
                sil_cnt_reg  <= sil_cnt_next;
                ovf_err_reg  <= ovf_err_next;
                nt_err_reg   <= nt_err_next;
                silent_reg   <= silent_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg.status            <= status_next;
            out_data_reg.pulse_width       <= width_next;
            out_data_reg.measurement_ready <= rdy_next;
            out_data_reg.overflow_error    <= ovf_err_next;
            out_data_reg.no_trigger_error  <= nt_err_next;
            out_data_reg.sensor_silent     <= silent_next;
        end
    end

endmodule

@@ rtl/echo_capture_validator.sv @@
// Echo capture validator.
// Input channel (in_valid/in_ready/in_data): one word per tick, capture event
// or acknowledge. Every accepted word yields exactly one output word
// (out_valid/out_ready/out_data) with the event status, the latched pulse
// width, the ready bit and the three error flags.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 is the
// 8-bit error threshold, index 1 the 16-bit silence threshold; other indexes
// are ignored. cfg_ready is always high; write only while the block is idle.
// An accepted word is written into the queue; the back end pops it when the
// output word is empty or being taken and registers the result on out_data.
// Throughput is one word per cycle while out_ready stays high.
// A queue of QUEUE_DEPTH commands sits between the decoder and the back end;
// in_ready drops only when that queue is full.
// Reset clears all counters, flags and the latched width, restores the
// thresholds to 10 and 1000, and empties the queue and the output register.
// When the receiver stalls, the output word holds, the queue fills, and then
// in_ready goes low until out_ready returns.
module echo_capture_validator #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  ecv_pkg::ecv_in_t              in_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output ecv_pkg::ecv_out_t             out_data,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [ecv_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [ecv_pkg::CfgDataW-1:0]  cfg_data
);
    import ecv_pkg::*;

    logic     push;
    logic     pop;
    logic     q_full;
    logic     q_valid;
    ecv_cmd_t cmd;
    ecv_cmd_t head;

    assign cfg_ready = 1'b1;

    ecv_front u_front (
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .push     (push),
        .cmd      (cmd),
        .q_full   (q_full)
    );

    ecv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .full     (q_full),
        .pop      (pop),
        .q_valid  (q_valid),
        .head     (head)
    );

    ecv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ tb/echo_capture_validator_tb.sv @@
`timescale 1ns / 100ps

module echo_capture_validator_tb;
    import ecv_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ecv_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ecv_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CfgIdxW-1:0] cfg_index = '0;
    logic [CfgDataW-1:0] cfg_data = '0;

    // predicted block state
    logic [CountW-1:0] err_thr;
    logic [SilenceW-1:0] sil_thr;
    logic [WidthW-1:0] held_width;
    logic held_ready;
    logic [2:0] prev_status;
    logic [CountW-1:0] ovf_cnt;
    logic [CountW-1:0] notrig_cnt;
    logic [CountW-1:0] good_cnt;
    logic [SilenceW-1:0] silent_ticks;
    logic ovf_err;
    logic notrig_err;
    logic silent_err;

    ecv_out_t expected_words[$];
    ecv_out_t want_word;
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    echo_capture_validator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic reset_echo_state();
        err_thr      = ErrThrReset;
        sil_thr      = SilThrReset;
        held_width   = '0;
        held_ready   = 1'b0;
        prev_status  = StNone;
        ovf_cnt      = '0;
        notrig_cnt   = '0;
        good_cnt     = '0;
        silent_ticks = '0;
        ovf_err      = 1'b0;
        notrig_err   = 1'b0;
        silent_err   = 1'b0;
    endtask

    function automatic ecv_out_t predict_echo(ecv_in_t w);
        ecv_out_t r;
        logic [2:0] st;
        case (w.func)
            FuncTick:
            begin
                if (silent_ticks != SilenceMax)
                    silent_ticks++;
                if (silent_ticks >= sil_thr)
                    silent_err = 1'b1;
            end
            FuncCapture:
            begin
                st = StNoCc3;
                if (w.cc3_flag)
                begin
                    silent_ticks = '0;
                    silent_err   = 1'b0;
                    st           = StDropped;
                    if (!w.trigger_seen)
                    begin
                        st = StNoTrig;
                        if (notrig_cnt != CountMax)
                            notrig_cnt++;
                        if (notrig_cnt >= err_thr)
                        begin
                            good_cnt   = '0;
                            notrig_err = 1'b1;
                        end
                    end
                    else if (w.overflow_seen)
                    begin
                        st = StOverflow;
                        if (ovf_cnt != CountMax)
                            ovf_cnt++;
                        if (ovf_cnt >= err_thr)
                        begin
                            good_cnt = '0;
                            ovf_err  = 1'b1;
                        end
                    end
                    else if (!held_ready)
                    begin
                        held_width = w.capture_value;
                        held_ready = 1'b1;
                        st         = StStored;
                    end
                    if (good_cnt != CountMax)
                        good_cnt++;
                    if (good_cnt >= err_thr)
                    begin
                        ovf_cnt    = '0;
                        notrig_cnt = '0;
                        ovf_err    = 1'b0;
                        notrig_err = 1'b0;
                    end
                end
                prev_status = st;
            end
            FuncAck:
                held_ready = 1'b0;
            default: ;
        endcase
        r.status            = prev_status;
        r.pulse_width       = held_width;
        r.measurement_ready = held_ready;
        r.overflow_error    = ovf_err;
        r.no_trigger_error  = notrig_err;
        r.sensor_silent     = silent_err;
        return r;
    endfunction

    function automatic ecv_in_t make_word(logic [1:0] func, logic cc3, logic trig,
                                          logic ovf, logic [WidthW-1:0] val);
        ecv_in_t w;
        w.func          = func;
        w.cc3_flag      = cc3;
        w.trigger_seen  = trig;
        w.overflow_seen = ovf;
        w.capture_value = val;
        return w;
    endfunction

    function automatic ecv_in_t random_word();
        ecv_in_t w;
        int pick;
        int vsel;
        pick = $urandom_range(99);
        vsel = $urandom_range(9);
        if (pick < 35)
            w.func = FuncTick;
        else if (pick < 80)
            w.func = FuncCapture;
        else
            w.func = FuncAck;
        w.cc3_flag      = ($urandom_range(9) != 0);
        w.trigger_seen  = ($urandom_range(9) > 1);
        w.overflow_seen = ($urandom_range(9) < 3);
        if (vsel == 0)
            w.capture_value = '0;
        else if (vsel == 1)
            w.capture_value = '1;
        else
            w.capture_value = WidthW'($urandom);
        return w;
    endfunction

    // valid stays high between back-to-back words
    task automatic send_word(input ecv_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_words.push_back(predict_echo(w));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        if (idx == RegErrThr)
            err_thr = val[CountW-1:0];
        else if (idx == RegSilThr)
            sil_thr = val;
    endtask

    task automatic set_thresholds(input int unsigned e, input int unsigned s);
        drain();
        write_reg(RegErrThr, CfgDataW'(e));
        write_reg(RegSilThr, CfgDataW'(s));
    endtask

    task automatic check_field(input string name, input int unsigned want, input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("output word with none expected");
                errors++;
            end
            else
            begin
                want_word = expected_words.pop_front();
                check_field("status", want_word.status, out_data.status);
                check_field("pulse_width", want_word.pulse_width, out_data.pulse_width);
                check_field("measurement_ready", want_word.measurement_ready,
                            out_data.measurement_ready);
                check_field("overflow_error", want_word.overflow_error,
                            out_data.overflow_error);
                check_field("no_trigger_error", want_word.no_trigger_error,
                            out_data.no_trigger_error);
                check_field("sensor_silent", want_word.sensor_silent, out_data.sensor_silent);
            end
        end
    end

    task automatic test_directed();
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        send_word(make_word(FuncAck, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncTick, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        send_word(make_word(FuncCapture, 1'b0, 1'b1, 1'b1, 16'hFFFF));
        send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'h0000));
        send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'hFFFF));
        send_word(make_word(FuncAck, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'hFFFF));
        send_word(make_word(FuncTick, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncAck, 1'b1, 1'b1, 1'b1, 16'h1234));
        send_word(make_word(FuncCapture, 1'b1, 1'b0, 1'b0, 16'h0001));
        send_word(make_word(FuncCapture, 1'b1, 1'b0, 1'b1, 16'h8000));
        send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b1, 16'h5A5A));
        send_word(make_word(FuncCapture, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncTick, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncAck, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'hA5A5));
    endtask

    task automatic test_error_flags();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_thresholds(3, 4);
        repeat (5) send_word(make_word(FuncTick, 1'b0, 1'b0, 1'b0, 16'h0000));
        send_word(make_word(FuncCapture, 1'b1, 1'b0, 1'b0, 16'h0000));
        repeat (3) send_word(make_word(FuncCapture, 1'b1, 1'b0, 1'b1, 16'h0000));
        repeat (4) send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b1, 16'hFFFF));
        repeat (3)
        begin
            send_word(make_word(FuncAck, 1'b0, 1'b0, 1'b0, 16'h0000));
            send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'($urandom)));
        end
    endtask

    task automatic test_saturation();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_thresholds(CountMax, SilenceMax);
        repeat (260) send_word(make_word(FuncCapture, 1'b1, 1'b0, 1'b0, 16'h0000));
        repeat (260) send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b1, 16'h0000));
        repeat (260) send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'($urandom)));
        send_word(make_word(FuncCapture, 1'b1, 1'b1, 1'b0, 16'h0000));
    endtask

    task automatic test_random(input int n, input int send_pct, input int recv_pct,
                               input int unsigned e, input int unsigned s);
        set_thresholds(e, s);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        repeat (n) send_word(random_word());
    endtask

    initial
    begin
        reset_echo_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_error_flags();
        test_saturation();
        test_random(210, 0, 0, $urandom_range(12, 1), $urandom_range(30, 1));
        test_random(210, 77, 0, 1, 1);
        test_random(210, 0, 77, CountMax, SilenceMax);
        test_random(210, 28, 28, $urandom_range(20, 1), $urandom_range(100, 1));
        drain();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ecv_pkg.sv
rtl/ecv_front.sv
rtl/ecv_queue.sv
rtl/ecv_back.sv
rtl/echo_capture_validator.sv
tb/echo_capture_validator_tb.sv
